>>> rtl/wacq_pkg.sv
// ----------------------------------------------------------------------------
// wacq_pkg
// Types and constants shared by the window average change qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package wacq_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned AVG_W      = 12;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned LIMIT_W    = 2;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // sum * 10 needs four more bits than the sum
  localparam int unsigned DIV_W      = SUM_W + 4;
  localparam int unsigned STEP_W     = $clog2(DIV_W);

  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(3);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(1);
  localparam logic [THR_W-1:0]    THR_RST    = THR_W'(120);
  localparam logic [LIMIT_W-1:0]  RUN_MAX    = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
  localparam logic [AVG_W-1:0]    AVG_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANGE_MARGIN  = 2'd0,
    CFG_CONFIRM_LIMIT  = 2'd1,
    CFG_LAMP_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_WINDOW_END = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic add_sample;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/wacq_if.sv
// ----------------------------------------------------------------------------
// wacq_if
// Handshake channels of the window average change qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

interface wacq_in_if
  import wacq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output operation, output sample_value, input ready);
  modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface wacq_out_if
  import wacq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] new_average;
  logic [AVG_W-1:0] held_average;
  logic             lamp_on;
  logic [CNT_W-1:0] sample_count;
  logic             window_empty;

  modport source (output valid, output new_average, output held_average, output lamp_on,
                  output sample_count, output window_empty, input ready);
  modport sink   (input valid, input new_average, input held_average, input lamp_on,
                  input sample_count, input window_empty, output ready);
endinterface

interface wacq_cfg_if
  import wacq_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/wacq_ctrl.sv
// ----------------------------------------------------------------------------
// wacq_ctrl
// Sequencer: takes items, runs the divider steps, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module wacq_ctrl
  import wacq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_op_i,
  output logic            in_ready_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_e'(in_op_i) == OP_SAMPLE) begin
            cmd_o.add_sample = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            step_d      = '0;
            state_d     = status_i.cnt_zero ? ST_FINISH : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending one");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished result not presented");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("item taken while busy");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q < STEP_W'(DIV_W)))
    else $error("divider step count overrun");

endmodule

`default_nettype wire

>>> rtl/wacq_dp.sv
// ----------------------------------------------------------------------------
// wacq_dp
// Datapath: accumulator, bit-serial divider, change qualifier, config regs.
// ----------------------------------------------------------------------------
`default_nettype none

module wacq_dp
  import wacq_pkg::*;
#(
  parameter logic [CNT_W-1:0] COUNT_CAP = '1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [AVG_W-1:0]           new_average_o,
  output logic [AVG_W-1:0]           held_average_o,
  output logic                       lamp_on_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic                       window_empty_o
);

  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [LIMIT_W-1:0]  run_q;
  logic [AVG_W-1:0]    held_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [THR_W-1:0]    thr_q;

  logic [DIV_W-1:0]    quo_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    dvsr_q;
  logic                empty_q;

  logic [SUM_W:0]      sum_ext;
  logic [DIV_W-1:0]    sum_x10;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic [AVG_W-1:0]    avg;
  logic [AVG_W-1:0]    diff;
  logic                changed;
  logic [LIMIT_W-1:0]  run_next;
  logic                take;
  logic [AVG_W-1:0]    held_next;

  assign status_o.cnt_zero = (cnt_q == '0);

  assign sum_ext = {1'b0, sum_q} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, sample_i};
  assign sum_x10 = {1'b0, sum_q, 3'b000} + {3'b000, sum_q, 1'b0};

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr_q});

  assign avg       = (quo_q > DIV_W'(AVG_MAX)) ? AVG_MAX : quo_q[AVG_W-1:0];
  assign diff      = (avg > held_q) ? (avg - held_q) : (held_q - avg);
  assign changed   = !empty_q && (diff > {{(AVG_W - MARGIN_W){1'b0}}, margin_q});
  assign run_next  = changed ? ((run_q == RUN_MAX) ? RUN_MAX : run_q + LIMIT_W'(1)) : '0;
  assign take      = (run_next > limit_q);
  assign held_next = take ? avg : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      run_q    <= '0;
      held_q   <= '0;
      margin_q <= MARGIN_RST;
      limit_q  <= LIMIT_RST;
      thr_q    <= THR_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CHANGE_MARGIN:  margin_q <= cfg_data_i[MARGIN_W-1:0];
          CFG_CONFIRM_LIMIT:  limit_q  <= cfg_data_i[LIMIT_W-1:0];
          CFG_LAMP_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.add_sample && (cnt_q < COUNT_CAP)) begin
        sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.start) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.finish) begin
        run_q  <= take ? '0 : run_next;
        held_q <= held_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q   <= (cnt_q == '0) ? '0 : sum_x10;
      rem_q   <= '0;
      dvsr_q  <= cnt_q;
      empty_q <= (cnt_q == '0);
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? CNT_W'(trial - {1'b0, dvsr_q}) : trial[CNT_W-1:0];
    end
    if (cmd_i.finish) begin
      new_average_o  <= avg;
      held_average_o <= held_next;
      lamp_on_o      <= (held_next >= thr_q);
      sample_count_o <= dvsr_q;
      window_empty_o <= empty_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/window_average_change_qualifier_core.sv
// ----------------------------------------------------------------------------
// window_average_change_qualifier_core
// Windowed sample average (x10) with debounced update of a held value.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                            handshake
//  in_i     in   operation, sample_value                            valid/ready
//  out_o    out  new_average, held_average, lamp_on,                valid/ready
//                sample_count, window_empty
//  cfg_i    in   index, data                                        valid/ready
//
//  Sample items: accepted back to back while the sequencer is idle.
//  Window end: idle, divide steps (bit-serial restoring divider, one
//  quotient bit per cycle), finish; an empty window goes idle to finish.
//  Reset restores registers to 3 / 1 / 120 and clears sum, count, run, held.
//  A finished result waits in the output register; new items are taken
//  meanwhile, and only the next window end stalls until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module window_average_change_qualifier_core
  import wacq_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1023
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wacq_in_if.sink   in_i,
  wacq_out_if.source out_o,
  wacq_cfg_if.sink  cfg_i
);

  localparam int unsigned CountLimit = (1 << CNT_W) - 1;
  localparam int unsigned CountCap   = (MAX_SAMPLES > CountLimit) ? CountLimit : MAX_SAMPLES;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  wacq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wacq_dp #(
    .COUNT_CAP (CNT_W'(CountCap))
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (in_i.sample_value),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .new_average_o  (out_o.new_average),
    .held_average_o (out_o.held_average),
    .lamp_on_o      (out_o.lamp_on),
    .sample_count_o (out_o.sample_count),
    .window_empty_o (out_o.window_empty)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_window_average_change_qualifier_core.sv
// ----------------------------------------------------------------------------
// tb_window_average_change_qualifier_core
// Self-checking bench for the windowed average change qualifier. Sample and
// window-end items go in through a queue-fed driver. A scoreboard tracks
// sum, count, change run and held value, and each result item on the output
// is compared with the oldest predicted window result. Register settings
// change between phases while the block is idle. Both handshakes get random
// gaps, with some phases run at full rate.
// ----------------------------------------------------------------------------
module tb_window_average_change_qualifier_core;
  import wacq_pkg::*;

  localparam int unsigned MAX_SAMPLES = 1023;
  localparam int unsigned CNT_CAP     = (MAX_SAMPLES < 1023) ? MAX_SAMPLES : 1023;
  localparam int unsigned SETTLE_CYC  = 32;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
  } wacq_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] new_avg;
    logic [AVG_W-1:0] held;
    logic             lamp;
    logic [CNT_W-1:0] count;
    logic             empty;
  } window_result_t;

  logic clk_i;
  logic rst_ni;

  wacq_in_if  in_if ();
  wacq_out_if out_if ();
  wacq_cfg_if cfg_if ();

  window_average_change_qualifier_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  wacq_item_t     item_q[$];
  window_result_t window_result_q[$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_empty;
  int unsigned held_updates;
  int unsigned mismatches;

  bit          steady;
  bit          in_taken;
  int unsigned gap_left;
  int unsigned stall_left;

  // scoreboard copy of registers and window state
  logic [MARGIN_W-1:0] margin_reg;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [THR_W-1:0]    thr_reg;
  logic [SUM_W-1:0]    run_sum;
  logic [CNT_W-1:0]    win_cnt;
  logic [LIMIT_W-1:0]  change_run;
  logic [AVG_W-1:0]    held_val;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("[window_average_change_qualifier_core] ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void absorb_item(wacq_item_t it);
    window_result_t r;
    int unsigned    acc;
    int unsigned    avg;
    int unsigned    diff;
    logic           changed;
    if (it.op == OP_SAMPLE) begin
      if (win_cnt < CNT_CAP) begin
        acc = run_sum + it.sample;
        run_sum = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
        win_cnt = win_cnt + 1'b1;
      end
      return;
    end
    avg = 0;
    changed = 1'b0;
    if (win_cnt != 0) begin
      avg = (run_sum * 10) / win_cnt;
      if (avg > AVG_MAX) avg = AVG_MAX;
      diff = (avg > held_val) ? avg - held_val : held_val - avg;
      changed = diff > margin_reg;
    end
    r.count = win_cnt;
    r.empty = (win_cnt == 0);
    run_sum = '0;
    win_cnt = '0;
    if (changed) begin
      if (change_run < RUN_MAX) change_run = change_run + 1'b1;
    end else begin
      change_run = '0;
    end
    if (change_run > limit_reg) begin
      change_run = '0;
      held_val = avg[AVG_W-1:0];
      held_updates++;
    end
    r.new_avg = avg[AVG_W-1:0];
    r.held = held_val;
    r.lamp = (held_val >= thr_reg);
    window_result_q.push_back(r);
  endfunction

  // input driver
  always @(negedge clk_i) begin
    wacq_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        it = item_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.operation <= it.op;
        in_if.sample_value <= it.sample;
        gap_left = steady ? 0 : pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    window_result_t e;
    wacq_item_t     it;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (window_result_q.size() == 0) begin
          $error("result item with no window end pending");
          mismatches++;
        end else begin
          e = window_result_q.pop_front();
          if (e.empty) n_empty++;
          if (out_if.new_average !== e.new_avg) begin
            $error("new_average: expected %0d, got %0d", e.new_avg, out_if.new_average);
            mismatches++;
          end
          if (out_if.held_average !== e.held) begin
            $error("held_average: expected %0d, got %0d", e.held, out_if.held_average);
            mismatches++;
          end
          if (out_if.lamp_on !== e.lamp) begin
            $error("lamp_on: expected %0d, got %0d", e.lamp, out_if.lamp_on);
            mismatches++;
          end
          if (out_if.sample_count !== e.count) begin
            $error("sample_count: expected %0d, got %0d", e.count, out_if.sample_count);
            mismatches++;
          end
          if (out_if.window_empty !== e.empty) begin
            $error("window_empty: expected %0d, got %0d", e.empty, out_if.window_empty);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        it.op = op_e'(in_if.operation);
        it.sample = in_if.sample_value;
        absorb_item(it);
        n_accepted++;
      end
    end
  end

  task automatic push_item(op_e op, logic [SAMPLE_W-1:0] s);
    wacq_item_t it;
    it.op = op;
    it.sample = s;
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_window(int unsigned n, int level, int spread);
    int v;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        v = $urandom_range(0, 255);
      end else begin
        v = level + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      push_item(OP_SAMPLE, v[SAMPLE_W-1:0]);
    end
    push_item(OP_WINDOW_END, SAMPLE_W'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    while (n_accepted != n_queued || window_result_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_CHANGE_MARGIN:  margin_reg = d[MARGIN_W-1:0];
      CFG_CONFIRM_LIMIT:  limit_reg = d[LIMIT_W-1:0];
      CFG_LAMP_THRESHOLD: thr_reg = d[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned m, int unsigned l, int unsigned t);
    write_reg(CFG_CHANGE_MARGIN, CFG_DATA_W'(m));
    write_reg(CFG_CONFIRM_LIMIT, CFG_DATA_W'(l));
    write_reg(CFG_LAMP_THRESHOLD, CFG_DATA_W'(t));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned m;
    int unsigned l;
    int unsigned t;
    int          level;
    int          spread;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_SAMPLE;
    in_if.sample_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_CHANGE_MARGIN;
    cfg_if.data = '0;
    steady = 1'b0;
    gap_left = 0;
    stall_left = 0;
    margin_reg = MARGIN_RST;
    limit_reg = LIMIT_RST;
    thr_reg = THR_RST;
    run_sum = '0;
    win_cnt = '0;
    change_run = '0;
    held_val = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty windows, extremes, confirm, lamp edge, margin edge
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd0);
    push_item(OP_WINDOW_END, 8'hFF);
    push_item(OP_SAMPLE, 8'd255);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd255);
    push_item(OP_SAMPLE, 8'd255);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd0);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd1);
    push_item(OP_SAMPLE, 8'd2);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd12);
    push_item(OP_SAMPLE, 8'd12);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd12);
    push_item(OP_WINDOW_END, 8'h00);
    push_item(OP_SAMPLE, 8'd12);
    push_item(OP_SAMPLE, 8'd12);
    push_item(OP_SAMPLE, 8'd13);
    push_item(OP_WINDOW_END, 8'h00);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin m = 0; l = 0; t = 0; end
        1: begin m = 255; l = 3; t = 4095; end
        2: begin m = 3; l = 1; t = 120; end
        3: begin m = 10; l = 2; t = 1500; end
        default: begin
          m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
          l = $urandom_range(0, 3);
          t = $urandom_range(0, 4095);
        end
      endcase
      set_regs(m, l, t);
      steady = ($urandom_range(0, 3) == 0);
      level = $urandom_range(0, 255);
      spread = $urandom_range(0, 4);
      if (phase == 3) push_window(1026, 200, 55);
      phase_items = 0;
      while (phase_items < 50) begin
        if ($urandom_range(0, 9) < 3) begin
          level = $urandom_range(0, 255);
          spread = $urandom_range(0, 4);
        end
        if ($urandom_range(0, 9) == 0) begin
          push_item(OP_WINDOW_END, SAMPLE_W'($urandom_range(0, 255)));
          phase_items += 1;
        end else begin
          t = $urandom_range(1, 8);
          push_window(t, level, spread);
          phase_items += t + 1;
        end
      end
      drain();
    end

    $display("%0d items accepted, %0d window results checked (%0d empty, %0d held updates)",
             n_accepted, n_results, n_empty, held_updates);
    $display("register settings covered margin 0..255, confirm limit 0..3, threshold 0..4095");
    if (mismatches == 0) begin
      $display("[window_average_change_qualifier_core] OK");
    end else begin
      $display("[window_average_change_qualifier_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/wacq_pkg.sv
rtl/wacq_if.sv
rtl/wacq_ctrl.sv
rtl/wacq_dp.sv
rtl/window_average_change_qualifier_core.sv
tb/sv/tb_window_average_change_qualifier_core.sv
